### rtl/ktks_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the keyed top-k score table.
// Used by ktks_ctrl, ktks_dp and keyed_top_k_score_table_top.
package ktks_pkg;

  localparam int SLOT_COUNT      = 32;
  localparam int VALUES_PER_SLOT = 3;
  localparam int SLOT_W          = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RANK_W          = (VALUES_PER_SLOT > 1) ? $clog2(VALUES_PER_SLOT) : 1;

  typedef logic signed [31:0] score_t;
  typedef score_t [VALUES_PER_SLOT-1:0] score_row_t;

  localparam score_t EMPTY_SCORE = -32'sd1;

  localparam logic [2:0] ACT_SUBMIT     = 3'd0;
  localparam logic [2:0] ACT_QUERY      = 3'd1;
  localparam logic [2:0] ACT_CLEAR_ALL  = 3'd2;
  localparam logic [2:0] ACT_FREE_KEY   = 3'd3;
  localparam logic [2:0] ACT_CLEAR_FLAG = 3'd4;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_NOT_RANKED = 3'd1;
  localparam logic [2:0] ST_UNSCORED   = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NEGATIVE   = 3'd4;

  localparam logic [1:0] KIND_UNSCORED = 2'd0;
  localparam logic [1:0] KIND_LOWER    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_LOAD,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic read_row;
    logic commit;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

  function automatic score_t entry_at(input score_row_t row, input int idx);
    score_t res;
    res = EMPTY_SCORE;
    for (int i = 0; i < VALUES_PER_SLOT; i++) begin
      if (i == idx) res = row[i];
    end
    return res;
  endfunction

endpackage

### rtl/ktks_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the keyed top-k score table: capture, tag scan, row read,
// update and result hand-off. Depends on ktks_pkg.
module ktks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ktks_pkg::dp_stat_t stat,
  output ktks_pkg::dp_cmd_t  cmd
);
  import ktks_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (stat.scan_last) state_nxt = S_SETTLE;
      S_SETTLE: state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_FINISH;
      S_FINISH: if (!stat.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SCAN:   cmd.scan     = 1'b1;
      S_SETTLE: cmd          = '0;
      S_LOAD:   cmd.read_row = 1'b1;
      S_UPDATE: cmd.commit   = 1'b1;
      S_FINISH: cmd.publish  = !stat.out_busy;
      default:  cmd          = '0;
    endcase
  end

endmodule

### rtl/ktks_dp.sv
`timescale 1ns / 1ps
// Datapath of the keyed top-k score table: tag and value memories, slot
// valid bits, scan compare, rank insert and result register. Depends on ktks_pkg.
module ktks_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ktks_pkg::dp_cmd_t  cmd,
  output ktks_pkg::dp_stat_t stat,
  input  logic [2:0]         in_action,
  input  logic [31:0]        in_key,
  input  logic [1:0]         in_score_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [1:0]         out_rank,
  output logic signed [31:0] out_best_first,
  output logic signed [31:0] out_best_second,
  output logic signed [31:0] out_best_third,
  output logic               out_changed
);
  import ktks_pkg::*;

  logic [31:0]       tag_mem [SLOT_COUNT];
  score_row_t        row_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_r, slot_vld_nxt;
  logic              dirty_r, dirty_nxt;

  logic [2:0]        action_r;
  logic [31:0]       key_r;
  logic [1:0]        kind_r;
  score_t            value_r;

  logic [SLOT_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              cmp_vld_r;
  logic [31:0]       tag_q_r;
  logic              hit_r, free_found_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r;
  score_row_t        row_q_r;

  logic [SLOT_W-1:0] sel_idx;
  score_row_t        row_eff, row_new, list_sel;
  logic              lower, ranked, wr_en;
  logic [RANK_W-1:0] rank_c;
  logic [2:0]        res_status_nxt;
  logic [RANK_W-1:0] res_rank_nxt;
  score_row_t        res_list_nxt;

  logic [2:0]        res_status_r;
  logic [RANK_W-1:0] res_rank_r;
  score_row_t        res_list_r;
  logic              res_changed_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [1:0]        out_rank_r;
  score_t            out_first_r, out_second_r, out_third_r;
  logic              out_changed_r;

  assign stat.scan_last = (scan_idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign stat.out_busy  = out_valid_r && out_stall;
  assign sel_idx        = hit_r ? hit_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r   <= in_action;
      key_r      <= (in_key == 32'd0) ? 32'd1 : in_key;
      kind_r     <= in_score_kind;
      value_r    <= in_value;
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
    end
    if (cmd.scan) begin
      tag_q_r   <= tag_mem[scan_idx_r];
      cmp_idx_r <= scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.capture) begin
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (slot_vld_r[cmp_idx_r] && tag_q_r == key_r && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!slot_vld_r[cmp_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && slot_vld_r[cmp_idx_r] && tag_q_r == key_r && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmp_vld_r && !slot_vld_r[cmp_idx_r] && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_row) begin
      row_q_r <= row_mem[sel_idx];
    end
    if (wr_en) begin
      row_mem[sel_idx] <= row_new;
      tag_mem[sel_idx] <= key_r;
    end
  end

  always_comb begin
    row_eff = row_q_r;
    if (!slot_vld_r[sel_idx]) begin
      for (int i = 0; i < VALUES_PER_SLOT; i++) row_eff[i] = EMPTY_SCORE;
    end
  end

  always_comb begin
    lower  = (kind_r == KIND_LOWER);
    ranked = 1'b0;
    rank_c = '0;
    for (int i = 0; i < VALUES_PER_SLOT; i++) begin
      if (!ranked && ($signed(row_eff[i]) == EMPTY_SCORE ||
          (lower ? ($signed(value_r) < $signed(row_eff[i]))
                 : ($signed(value_r) > $signed(row_eff[i]))))) begin
        ranked = 1'b1;
        rank_c = RANK_W'(i);
      end
    end
    for (int i = 0; i < VALUES_PER_SLOT; i++) begin
      if (i < int'(rank_c)) begin
        row_new[i] = row_eff[i];
      end else if (i == int'(rank_c)) begin
        row_new[i] = value_r;
      end else begin
        row_new[i] = entry_at(row_eff, i - 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VALUES_PER_SLOT; i++) begin
      list_sel[i] = hit_r ? row_q_r[i] : EMPTY_SCORE;
      res_list_nxt[i] = EMPTY_SCORE;
    end
    res_status_nxt = ST_DONE;
    res_rank_nxt   = '0;
    slot_vld_nxt   = slot_vld_r;
    dirty_nxt      = dirty_r;
    wr_en          = 1'b0;
    unique case (action_r)
      ACT_SUBMIT: begin
        res_list_nxt = list_sel;
        if ($signed(value_r) < 0) begin
          res_status_nxt = ST_NEGATIVE;
        end else if (kind_r == KIND_UNSCORED) begin
          res_status_nxt = ST_UNSCORED;
        end else if (!hit_r && !free_found_r) begin
          res_status_nxt = ST_FULL;
        end else if (!ranked) begin
          res_status_nxt = ST_NOT_RANKED;
        end else begin
          wr_en                 = cmd.commit;
          slot_vld_nxt[sel_idx] = 1'b1;
          dirty_nxt             = 1'b1;
          res_rank_nxt          = rank_c;
          res_list_nxt          = row_new;
        end
      end
      ACT_QUERY: begin
        if (kind_r == KIND_UNSCORED) begin
          res_status_nxt = ST_UNSCORED;
        end else begin
          res_list_nxt = list_sel;
        end
      end
      ACT_CLEAR_ALL: begin
        slot_vld_nxt = '0;
        dirty_nxt    = 1'b1;
      end
      ACT_FREE_KEY: begin
        if (hit_r) begin
          slot_vld_nxt[hit_idx_r] = 1'b0;
          dirty_nxt               = 1'b1;
        end
      end
      ACT_CLEAR_FLAG: begin
        dirty_nxt    = 1'b0;
        res_list_nxt = list_sel;
      end
      default: res_list_nxt = list_sel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      dirty_r    <= 1'b0;
    end else if (cmd.commit) begin
      slot_vld_r <= slot_vld_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r  <= res_status_nxt;
      res_rank_r    <= res_rank_nxt;
      res_list_r    <= res_list_nxt;
      res_changed_r <= dirty_nxt;
    end
    if (cmd.publish) begin
      out_status_r  <= res_status_r;
      out_rank_r    <= 2'(res_rank_r);
      out_first_r   <= entry_at(res_list_r, 0);
      out_second_r  <= entry_at(res_list_r, 1);
      out_third_r   <= entry_at(res_list_r, 2);
      out_changed_r <= res_changed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_rank        = out_rank_r;
  assign out_best_first  = out_first_r;
  assign out_best_second = out_second_r;
  assign out_best_third  = out_third_r;
  assign out_changed     = out_changed_r;

endmodule

### rtl/keyed_top_k_score_table_top.sv
`timescale 1ns / 1ps
// Top level of the keyed top-k score table: controller plus datapath.
// Depends on ktks_pkg, ktks_ctrl and ktks_dp.
//
// Usage: one request beat on the in_ channel (action, key, score_kind,
// value) yields exactly one result beat on the out_ channel (status, rank,
// three best values, changed flag). Beats move when valid is high and
// stall is low.
// One request is in flight at a time. The time from request acceptance to
// result valid is set mainly by the tag scan, which reads one slot tag a
// cycle from the tag memory.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; if that result is still stalled when
// the next one is ready, the block holds in its final state until the beat
// is taken.
// Reset (rst_n low, synchronous) frees every slot, empties every list,
// clears the change flag and drops any pending result.
module keyed_top_k_score_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [31:0]        in_key,
  input  logic [1:0]         in_score_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [1:0]         out_rank,
  output logic signed [31:0] out_best_first,
  output logic signed [31:0] out_best_second,
  output logic signed [31:0] out_best_third,
  output logic               out_changed
);
  import ktks_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ktks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ktks_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_score_kind   (in_score_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_rank        (out_rank),
    .out_best_first  (out_best_first),
    .out_best_second (out_best_second),
    .out_best_third  (out_best_third),
    .out_changed     (out_changed)
  );

endmodule
